// ===== rtl/text_escape_and_line_wrap_top_macros.svh =====
// assertion helpers for the text wrap block
`ifndef TEXT_ESCAPE_AND_LINE_WRAP_TOP_MACROS_SVH
`define TEXT_ESCAPE_AND_LINE_WRAP_TOP_MACROS_SVH

// condition must hold at every edge out of reset
`define TXW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies consequence in the following cycle
`define TXW_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/txw_pkg.sv =====
package txw_pkg;

  localparam int LINE_BUFFER = 80;
  localparam int MAX_LEVEL   = 10;
  localparam int CHUNK_BYTES = 8;

  localparam int FILL_W  = $clog2(LINE_BUFFER + 1);
  localparam int ADDR_W  = $clog2(LINE_BUFFER);
  localparam int LVL_W   = $clog2(MAX_LEVEL + 1);
  localparam int CIDX_W  = $clog2(CHUNK_BYTES);

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic [LVL_W-1:0] LVL_SPACE = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_COMMA = LVL_W'(4);
  localparam logic [LVL_W-1:0] LVL_SEMI  = LVL_W'(5);
  localparam logic [LVL_W-1:0] LVL_COLON = LVL_W'(6);
  localparam logic [LVL_W-1:0] LVL_DOT   = LVL_W'(7);

  typedef enum logic {
    CFG_SEVEN_BIT = 1'b0,
    CFG_PREFORMAT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       fin;
    logic [7:0] data;
  } pack_req_t;

  typedef struct packed {
    logic ready_push;
    logic ready_fin;
  } pack_sts_t;

endpackage

// ===== rtl/text_escape_and_line_wrap_top.sv =====
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_item_t (op, char_code)
// out_    | output    | out_valid/out_stall| out_item_t (out_bytes, byte_count, last)
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// a plain byte goes through accept, store and close of the item chunk; an escape stores
// each character of its expansion in turn; a line cut or dump reads and then emits each
// byte moved, since every byte goes through the single registered read port of the line store
// reset is synchronous active low and clears control state; store contents stay undefined
// out_stall holds the chunk; while it is held the sequencer waits on a full packer, or to close on a nonempty one
module text_escape_and_line_wrap_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  txw_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output txw_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic              cfg_data
);
  import txw_pkg::*;
  `include "text_escape_and_line_wrap_top_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CHAR, S_DUMP_RD, S_DUMP_EM, S_DUMP_END,
    S_CUT_RD, S_CUT_EM, S_CUT_NL, S_COPY_RD, S_COPY_WR, S_OP_NL, S_FIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    seven_r, pre_r;
  logic                    op_r, op_nxt;
  logic [7:0]              ch_in_r, ch_in_nxt;
  logic [2:0]              k_r, k_nxt, n_r, n_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [FILL_W-1:0]       idx_r, idx_nxt, lim_r, lim_nxt, skip_r, skip_nxt;
  logic [MAX_LEVEL:0][FILL_W-1:0] bp_r, bp_nxt;
  logic [MAX_LEVEL:0]      bv_r, bv_nxt;
  logic [LVL_W-1:0]        best_r, best_nxt;
  logic                    ovf_r, ovf_nxt, dovf_r, dovf_nxt;
  logic [7:0]              prev_r, prev_nxt;

  // line store port
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;

  pack_req_t preq;
  pack_sts_t psts;

  // decimal digits of a high byte
  logic [7:0]  hund, rem8, tens, ones;
  logic [15:0] tprod;
  always_comb begin
    hund  = (ch_in_r >= 8'd200) ? 8'd2 : 8'd1;
    rem8  = ch_in_r - ((ch_in_r >= 8'd200) ? 8'd200 : 8'd100);
    tprod = 16'(rem8) * 16'd205;
    tens  = 8'(tprod >> 11);
    ones  = rem8 - 8'(tens * 8'd10);
  end

  // character k of the escaped expansion
  logic [7:0] ch;
  always_comb begin
    ch = ch_in_r;
    if (ch_in_r == CH_AMP) begin
      case (k_r)
        3'd0:    ch = CH_AMP;
        3'd1:    ch = 8'h61;
        3'd2:    ch = 8'h6d;
        3'd3:    ch = 8'h70;
        default: ch = CH_SEMI;
      endcase
    end else if (ch_in_r == CH_LT) begin
      case (k_r)
        3'd0:    ch = CH_AMP;
        3'd1:    ch = 8'h6c;
        3'd2:    ch = 8'h74;
        default: ch = CH_SEMI;
      endcase
    end else if (seven_r && ch_in_r[7]) begin
      case (k_r)
        3'd0:    ch = CH_AMP;
        3'd1:    ch = 8'h30 + hund;
        3'd2:    ch = 8'h30 + tens;
        3'd3:    ch = 8'h30 + ones;
        default: ch = CH_SEMI;
      endcase
    end
  end

  logic [7:0]              cs;
  logic [FILL_W-1:0]       fill_inc, pos;
  logic [LVL_W-1:0]        lvl, top;
  logic [MAX_LEVEL:0][FILL_W-1:0] bp_w;
  logic [MAX_LEVEL:0]      bv_w;
  logic [LVL_W-1:0]        best_w;
  logic                    adv;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ch_in_nxt = ch_in_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    skip_nxt  = skip_r;
    bp_nxt    = bp_r;
    bv_nxt    = bv_r;
    best_nxt  = best_r;
    ovf_nxt   = ovf_r;
    dovf_nxt  = dovf_r;
    prev_nxt  = prev_r;
    we        = 1'b0;
    waddr     = fill_r[ADDR_W-1:0];
    wdata     = 8'h00;
    raddr     = idx_r[ADDR_W-1:0];
    preq      = '0;
    adv       = 1'b0;
    cs        = (ch == CH_NL && !pre_r) ? CH_SP : ch;
    fill_inc  = fill_r + FILL_W'(1);
    lvl       = LVL_SPACE;
    bp_w      = bp_r;
    bv_w      = bv_r;
    best_w    = best_r;
    pos       = '0;
    top       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          ch_in_nxt = in_data.char_code;
          k_nxt     = 3'd0;
          if (in_data.char_code == CH_AMP) begin
            n_nxt = 3'd5;
          end else if (in_data.char_code == CH_LT) begin
            n_nxt = 3'd4;
          end else if (seven_r && in_data.char_code[7]) begin
            n_nxt = 3'd5;
          end else begin
            n_nxt = 3'd1;
          end
          if (in_data.op) begin
            idx_nxt   = '0;
            lim_nxt   = fill_r;
            dovf_nxt  = 1'b0;
            state_nxt = (fill_r == '0) ? S_DUMP_END : S_DUMP_RD;
          end else begin
            state_nxt = S_CHAR;
          end
        end
      end

      S_CHAR: begin
        we       = 1'b1;
        wdata    = cs;
        prev_nxt = cs;
        fill_nxt = fill_inc;
        if (ch == CH_NL && pre_r) begin
          idx_nxt   = '0;
          lim_nxt   = fill_inc;
          dovf_nxt  = 1'b0;
          state_nxt = S_DUMP_RD;
        end else begin
          if (!pre_r && cs == CH_SP) begin
            if (fill_r != '0) begin
              case (prev_r)
                CH_COMMA: lvl = LVL_COMMA;
                CH_SEMI:  lvl = LVL_SEMI;
                CH_COLON: lvl = LVL_COLON;
                CH_DOT:   lvl = LVL_DOT;
                default:  lvl = LVL_SPACE;
              endcase
            end
            bp_w[lvl] = fill_r;
            bv_w[lvl] = 1'b1;
            if (lvl >= best_r) begin
              best_w = lvl;
            end
          end
          bp_nxt   = bp_w;
          bv_nxt   = bv_w;
          best_nxt = best_w;
          if (fill_inc >= FILL_W'(LINE_BUFFER - 1) || (ovf_r && best_w != '0)) begin
            if (best_w != '0) begin
              pos = bp_w[best_w];
              if (pos >= fill_inc) begin
                pos = fill_r;
              end
              lim_nxt   = pos;
              idx_nxt   = '0;
              state_nxt = (pos == '0) ? S_CUT_NL : S_CUT_RD;
            end else begin
              idx_nxt   = '0;
              lim_nxt   = fill_inc;
              dovf_nxt  = 1'b1;
              state_nxt = S_DUMP_RD;
            end
          end else begin
            adv = 1'b1;
          end
        end
      end

      S_DUMP_RD: state_nxt = S_DUMP_EM;

      S_DUMP_EM: begin
        preq.data = rdata;
        preq.push = psts.ready_push;
        if (psts.ready_push) begin
          idx_nxt   = idx_r + FILL_W'(1);
          state_nxt = (idx_r + FILL_W'(1) == lim_r) ? S_DUMP_END : S_DUMP_RD;
        end
      end

      S_DUMP_END: begin
        fill_nxt = '0;
        bp_nxt   = '0;
        bv_nxt   = '0;
        best_nxt = '0;
        ovf_nxt  = ovf_r | dovf_r;
        if (op_r) begin
          state_nxt = S_OP_NL;
        end else begin
          adv = 1'b1;
        end
      end

      S_CUT_RD: state_nxt = S_CUT_EM;

      S_CUT_EM: begin
        preq.data = rdata;
        preq.push = psts.ready_push;
        if (psts.ready_push) begin
          idx_nxt   = idx_r + FILL_W'(1);
          state_nxt = (idx_r + FILL_W'(1) == lim_r) ? S_CUT_NL : S_CUT_RD;
        end
      end

      S_CUT_NL: begin
        preq.data = CH_NL;
        preq.push = psts.ready_push;
        if (psts.ready_push) begin
          // rebase surviving breaks past the cut space
          for (int i = 0; i <= MAX_LEVEL; i++) begin
            if (bv_r[i] && bp_r[i] > lim_r + FILL_W'(1)) begin
              bp_nxt[i] = bp_r[i] - (lim_r + FILL_W'(1));
              top       = LVL_W'(i);
            end else begin
              bv_nxt[i] = 1'b0;
              bp_nxt[i] = '0;
            end
          end
          best_nxt = top;
          ovf_nxt  = 1'b0;
          skip_nxt = lim_r + FILL_W'(1);
          idx_nxt  = lim_r + FILL_W'(1);
          lim_nxt  = fill_r;
          fill_nxt = fill_r - (lim_r + FILL_W'(1));
          if (lim_r + FILL_W'(1) == fill_r) begin
            adv = 1'b1;
          end else begin
            state_nxt = S_COPY_RD;
          end
        end
      end

      S_COPY_RD: state_nxt = S_COPY_WR;

      S_COPY_WR: begin
        we      = 1'b1;
        waddr   = ADDR_W'(idx_r - skip_r);
        wdata   = rdata;
        idx_nxt = idx_r + FILL_W'(1);
        if (idx_r + FILL_W'(1) == lim_r) begin
          adv = 1'b1;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end

      S_OP_NL: begin
        preq.data = CH_NL;
        preq.push = psts.ready_push;
        if (psts.ready_push) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        preq.fin = 1'b1;
        if (psts.ready_fin) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // move on to the next character of the item, or close the item
    if (adv) begin
      if (k_r + 3'd1 == n_r) begin
        state_nxt = S_FIN;
      end else begin
        k_nxt     = k_r + 3'd1;
        state_nxt = S_CHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seven_r <= 1'b0;
      pre_r   <= 1'b0;
      fill_r  <= '0;
      bp_r    <= '0;
      bv_r    <= '0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bp_r    <= bp_nxt;
      bv_r    <= bv_nxt;
      best_r  <= best_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SEVEN_BIT: seven_r <= cfg_data;
          CFG_PREFORMAT: pre_r   <= cfg_data;
          default:       ;
        endcase
      end
    end
    op_r    <= op_nxt;
    ch_in_r <= ch_in_nxt;
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
    lim_r   <= lim_nxt;
    skip_r  <= skip_nxt;
    dovf_r  <= dovf_nxt;
    prev_r  <= prev_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  txw_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  txw_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (preq),
    .sts       (psts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a settled store never holds a full line
  `TXW_ASSERT_ALWAYS(a_fill_idle, (state_r != S_IDLE) || (fill_r < FILL_W'(LINE_BUFFER - 1)), "line store left too full")
  // a new item blocks the input until its work is done
  `TXW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not blocked after transfer")
  // best level always names a valid break
  `TXW_ASSERT_ALWAYS(a_best_valid, (best_r == '0) || bv_r[best_r], "best level without a break")

endmodule

// ===== rtl/txw_store.sv =====
module txw_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [txw_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [txw_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import txw_pkg::*;

  logic [7:0] mem [LINE_BUFFER];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/txw_pack.sv =====
module txw_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  txw_pkg::pack_req_t  req,
  output txw_pkg::pack_sts_t  sts,
  output logic                out_valid,
  input  logic                out_stall,
  output txw_pkg::out_item_t  out_data
);
  import txw_pkg::*;

  logic [CHUNK_BYTES-1:0][7:0] acc_r, acc_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_data_r, out_data_nxt;

  assign sts = '{ready_push: (cnt_r != 4'(CHUNK_BYTES)) || !out_valid_r,
                 ready_fin:  (cnt_r == 4'd0) || !out_valid_r};

  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (req.push && sts.ready_push) begin
      if (cnt_r == 4'(CHUNK_BYTES)) begin
        out_data_nxt  = '{out_bytes: 64'(acc_r), byte_count: cnt_r, last: 1'b0};
        out_valid_nxt = 1'b1;
        acc_nxt       = '0;
        acc_nxt[0]    = req.data;
        cnt_nxt       = 4'd1;
      end else begin
        acc_nxt[cnt_r[CIDX_W-1:0]] = req.data;
        cnt_nxt                    = cnt_r + 4'd1;
      end
    end else if (req.fin && sts.ready_fin && cnt_r != 4'd0) begin
      out_data_nxt  = '{out_bytes: 64'(acc_r), byte_count: cnt_r, last: 1'b1};
      out_valid_nxt = 1'b1;
      acc_nxt       = '0;
      cnt_nxt       = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import txw_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic      cfg_data;

  text_escape_and_line_wrap_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // drain time after the last chunk, to cover a full-store cut that moves every byte
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int CHUNK_CAP     = 64;

  // ---------------------------------------------------------------------------
  // wrap model: escaped text, weighted break points, chunk packing
  // ---------------------------------------------------------------------------
  logic [7:0]  line_buf [LINE_BUFFER];
  int          line_fill;
  int          brk_pos [MAX_LEVEL+1];
  logic [MAX_LEVEL:0] brk_ok;
  int          top_level;
  bit          overflowed;
  bit          mode_seven_bit;
  bit          mode_preformat;
  logic [7:0]  emitted [$];
  out_item_t   chunks_due [$];

  function automatic void clear_breaks();
    for (int i = 0; i <= MAX_LEVEL; i++) brk_pos[i] = 0;
    brk_ok    = '0;
    top_level = 0;
  endfunction

  function automatic void flush_line();
    for (int i = 0; i < line_fill; i++) emitted.push_back(line_buf[i]);
    line_fill = 0;
    clear_breaks();
  endfunction

  // emit up to the best break, that space becomes a newline, remainder shifts down
  function automatic void cut_line();
    int pos;
    int skip;
    int keep;
    pos  = brk_pos[top_level];
    keep = 0;
    if (pos >= line_fill) pos = line_fill - 1;
    for (int i = 0; i < pos; i++) emitted.push_back(line_buf[i]);
    emitted.push_back(CH_NL);
    skip = pos + 1;
    for (int i = skip; i < line_fill; i++) line_buf[i-skip] = line_buf[i];
    for (int i = 0; i <= MAX_LEVEL; i++) begin
      if (brk_ok[i] && brk_pos[i] > skip) begin
        brk_pos[i] -= skip;
        keep = i;
      end else begin
        brk_ok[i]  = 1'b0;
        brk_pos[i] = 0;
      end
    end
    top_level  = keep;
    line_fill -= skip;
    overflowed = 0;
  endfunction

  function automatic void put_char(logic [7:0] c);
    int lvl;
    if (line_fill >= LINE_BUFFER) flush_line();
    line_buf[line_fill] = c;
    line_fill++;
    if (c == CH_NL) begin
      if (mode_preformat) begin
        flush_line();
        return;
      end
      c = CH_SP;
      line_buf[line_fill-1] = c;
    end
    if (!mode_preformat && c == CH_SP) begin
      lvl = int'(LVL_SPACE);
      if (line_fill >= 2) begin
        case (line_buf[line_fill-2])
          CH_COMMA: lvl = int'(LVL_COMMA);
          CH_SEMI:  lvl = int'(LVL_SEMI);
          CH_COLON: lvl = int'(LVL_COLON);
          CH_DOT:   lvl = int'(LVL_DOT);
          default:  lvl = int'(LVL_SPACE);
        endcase
      end
      brk_pos[lvl] = line_fill - 1;
      brk_ok[lvl]  = 1'b1;
      if (lvl >= top_level) top_level = lvl;
    end
    if (line_fill >= LINE_BUFFER - 1 || (overflowed && top_level != 0)) begin
      if (top_level != 0) cut_line();
      else begin
        flush_line();
        overflowed = 1;
      end
    end
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // advance the model by one item and queue the chunks it produces
  function automatic void wrap_item(in_item_t it, bit queue_chunks);
    int        n;
    int        cnt;
    out_item_t ch;
    emitted.delete();
    if (it.op) begin
      flush_line();
      emitted.push_back(CH_NL);
    end else if (it.char_code == CH_AMP) put_text("&amp;");
    else if (it.char_code == CH_LT) put_text("&lt;");
    else if (mode_seven_bit && it.char_code > 127) begin
      put_char(CH_AMP);
      put_char(8'("0") + it.char_code / 100);
      put_char(8'("0") + (it.char_code / 10) % 10);
      put_char(8'("0") + it.char_code % 10);
      put_char(CH_SEMI);
    end else put_char(it.char_code);
    if (!queue_chunks) return;
    n = (emitted.size() + CHUNK_BYTES - 1) / CHUNK_BYTES;
    if (n > CHUNK_CAP) n = CHUNK_CAP;
    for (int k = 0; k < n; k++) begin
      cnt = emitted.size() - k * CHUNK_BYTES;
      if (cnt > CHUNK_BYTES) cnt = CHUNK_BYTES;
      ch.out_bytes = '0;
      for (int i = 0; i < cnt; i++) ch.out_bytes[8*i +: 8] = emitted[k*CHUNK_BYTES + i];
      ch.byte_count = 4'(cnt);
      ch.last       = (k + 1 == n);
      chunks_due.push_back(ch);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  int errors;

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  out_item_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (chunks_due.size() == 0) report_mismatch("chunk with nothing pending");
      else begin
        want = chunks_due.pop_front();
        if (out_data.out_bytes !== want.out_bytes)
          report_mismatch($sformatf("out_bytes %h, want %h", out_data.out_bytes,
                                    want.out_bytes));
        if (out_data.byte_count !== want.byte_count)
          report_mismatch($sformatf("byte_count %0d, want %0d", out_data.byte_count,
                                    want.byte_count));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_data.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // clock, receiver stalls, limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  bit want_hold;
  bit hold_done;

  // receiver: mostly no stall, short stalls, a few long ones, and one long hold-off
  initial begin
    int r;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        out_stall <= 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        hold_done = 1;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 65) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(8)) @(posedge clk);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(60, 20)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sender and register writes
  // ---------------------------------------------------------------------------
  bit no_gaps;

  // one register transfer; the caller drops cfg_valid after its last write
  task automatic write_reg(cfg_idx_t idx, bit val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SEVEN_BIT) mode_seven_bit = val;
    else mode_preformat = val;
  endtask

  // registers change only once the block has drained
  task automatic set_modes(bit sb, bit pf);
    in_valid <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_SEVEN_BIT, sb);
    write_reg(CFG_PREFORMAT, pf);
    cfg_valid <= 1'b0;
  endtask

  int unsigned gap_left;

  // one transfer; typed chunk overrides the model's for rows read off at a glance
  task automatic send_item(in_item_t it, bit typed, logic [63:0] t_bytes, int t_cnt);
    out_item_t t;
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    wrap_item(it, !typed);
    if (typed) begin
      t.out_bytes  = t_bytes;
      t.byte_count = 4'(t_cnt);
      t.last       = 1'b1;
      chunks_due.push_back(t);
    end
    if (no_gaps) gap_left = 0;
    else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: gap_left = 0;
        5, 6, 7, 8:    gap_left = $urandom_range(3, 1);
        default:       gap_left = $urandom_range(40, 10);
      endcase
    end
  endtask

  typedef struct {
    bit          sb;
    bit          pf;
    bit          op;
    logic [7:0]  ch;
    bit          typed;
    logic [63:0] bytes;
    int          cnt;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{0, 0, 1, 8'h00, 1, 64'h0a, 1},               // empty store flush
    '{0, 0, 0, CH_AMP, 0, 0, 0},
    '{0, 0, 1, 8'hff, 1, 64'h0a3b706d6126, 6},    // char ignored on flush
    '{0, 0, 0, CH_LT, 0, 0, 0},
    '{0, 0, 0, 8'h00, 0, 0, 0},
    '{0, 0, 0, 8'hff, 0, 0, 0},                   // raw high byte
    '{0, 0, 1, 8'h00, 0, 0, 0},
    '{1, 0, 0, 8'hff, 0, 0, 0},
    '{1, 0, 1, 8'h00, 1, 64'h0a3b35353226, 6},    // &255;
    '{1, 0, 0, 8'h80, 0, 0, 0},
    '{1, 0, 0, 8'h7f, 0, 0, 0},
    '{1, 0, 0, CH_COMMA, 0, 0, 0},
    '{1, 0, 0, CH_SP, 0, 0, 0},
    '{1, 0, 0, CH_SEMI, 0, 0, 0},
    '{1, 0, 0, CH_SP, 0, 0, 0},
    '{1, 0, 0, CH_COLON, 0, 0, 0},
    '{1, 0, 0, CH_SP, 0, 0, 0},
    '{1, 0, 0, CH_DOT, 0, 0, 0},
    '{1, 0, 0, CH_SP, 0, 0, 0},
    '{1, 0, 0, CH_NL, 0, 0, 0},                   // newline as a space
    '{1, 0, 1, 8'h00, 0, 0, 0},
    '{0, 1, 0, 8'h61, 0, 0, 0},
    '{0, 1, 0, CH_NL, 0, 0, 0},                   // preformatted newline flushes
    '{0, 1, 1, 8'h00, 1, 64'h0a, 1}
  };

  // text-like byte: words, punctuated breaks, escapes, odd bytes, newlines
  function automatic in_item_t text_item();
    in_item_t it;
    int r;
    it.op = 1'b0;
    r = $urandom_range(99);
    if (r < 58)      it.char_code = 8'(8'h61 + $urandom_range(25));
    else if (r < 72) it.char_code = CH_SP;
    else if (r < 80) begin
      case ($urandom_range(3))
        0: it.char_code = CH_COMMA;
        1: it.char_code = CH_SEMI;
        2: it.char_code = CH_COLON;
        default: it.char_code = CH_DOT;
      endcase
    end
    else if (r < 85) it.char_code = $urandom_range(1) ? CH_AMP : CH_LT;
    else if (r < 93) it.char_code = 8'($urandom_range(255));
    else if (r < 97) it.char_code = CH_NL;
    else begin
      it.op = 1'b1;
      it.char_code = 8'($urandom_range(255));
    end
    return it;
  endfunction

  initial begin
    bit        cur_sb;
    bit        cur_pf;
    in_item_t  it;
    int        run;
    bit        phase_sb [5] = '{0, 1, 0, 1, 0};
    bit        phase_pf [5] = '{0, 0, 1, 1, 0};

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SEVEN_BIT;
    cfg_data  = 1'b0;
    errors    = 0;
    gap_left  = 0;
    line_fill = 0;
    overflowed = 0;
    mode_seven_bit = 0;
    mode_preformat = 0;
    clear_breaks();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; modes are rewritten only when a row asks for a change
    cur_sb = 0;
    cur_pf = 0;
    set_modes(0, 0);
    foreach (directed[i]) begin
      if (directed[i].sb != cur_sb || directed[i].pf != cur_pf) begin
        cur_sb = directed[i].sb;
        cur_pf = directed[i].pf;
        set_modes(cur_sb, cur_pf);
      end
      it.op        = directed[i].op;
      it.char_code = directed[i].ch;
      send_item(it, directed[i].typed, directed[i].bytes, directed[i].cnt);
    end

    // random phases over every mode pairing
    for (int p = 0; p < 5; p++) begin
      set_modes(phase_sb[p], phase_pf[p]);
      no_gaps = (p == 3);
      if (p == 1) want_hold = 1;
      for (int n = 0; n < 38; n++) begin
        if ($urandom_range(11) == 0) begin
          // unbroken word, at times long enough to fill the store
          run = $urandom_range(90, 20);
          for (int k = 0; k < run && n < 38; k++, n++) begin
            it.op = 1'b0;
            it.char_code = 8'(8'h41 + $urandom_range(25));
            send_item(it, 0, '0, 0);
          end
        end else send_item(text_item(), 0, '0, 0);
      end
    end
    in_valid <= 1'b0;

    while (chunks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
